FILE: rtl/core/bbe_pkg.sv
// bbe_pkg: shared types and constants for the edge-aware 3x3 box blur
// used by the front, queue and back modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bbe_pkg;

    typedef logic [23:0] pixel_t;   // [7:0] red, [15:8] green, [23:16] blue

    // window slot k*3+i: column k (0 oldest), row i (0 top)
    typedef struct packed {
        pixel_t [8:0] pix;
        logic [8:0]   vld;
        logic         eor;
        logic         eof;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_PIX2,
        ST_DR1,
        ST_DR2,
        ST_DR3
    } front_state_t;

    localparam logic [7:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_IMAGE_HEIGHT = 8'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int RECIP_SHIFT = 20;

    // ceil(2^20 / (2*count)) for the window sizes that occur
    function automatic logic [19:0] recip(input logic [3:0] cnt);
        logic [19:0] m;
        case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = 20'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/box_blur_3x3_edge_aware_unit.sv
// box_blur_3x3_edge_aware_unit: top level of the edge-aware 3x3 rgb box blur
// depends on bbe_pkg, bbe_front, bbe_queue, bbe_back, bbe_ram
//
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | s_tdata rgb pixel, s_tuser mode (1 = drain)
//  m_      | out | m_tvalid / m_tready    | m_tdata blurred rgb, m_tlast end of run,
//          |     |                        | m_tuser end of frame
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// a pixel passes ST_PIX in the front and pushes at most one job; at a row end
// below the top row it also passes ST_PIX2 for a second job. a drain item passes
// ST_DR1, ST_DR2 and ST_DR3, for the line buffer reads of its three columns.
// s_tready waits for an empty job queue; the back registers the sums, then divides
// into the output register, and m_tready stalls back up through the queue to s_tready.
// synchronous active-low reset; the line buffers are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_edge_aware_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // red_out, green_out, blue_out
    output logic             m_tlast,   // end_of_run
    output logic             m_tuser    // end_of_frame
);
    import bbe_pkg::*;

    logic push, pop, q_empty, q_full;
    job_t push_job, pop_job;

    bbe_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_empty   (q_empty),
        .push      (push),
        .push_job  (push_job)
    );

    bbe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    bbe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!q_empty),
        .job       (pop_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("job queue overflow");

    a_busy_on_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !s_tready)
        else $error("input ready while front is pushing a job");

    a_eof_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end of frame without end of run");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("pop from empty job queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/bbe_ram.sv
// bbe_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/bbe_front.sv
// bbe_front: config registers, frame counters, line buffers and window;
// turns each accepted item into blur jobs. depends on bbe_pkg, bbe_ram
`timescale 1ns / 1ps
`default_nettype none

module bbe_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [12:0]   cfg_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,
    input  wire logic          s_tuser,
    input  wire logic          q_empty,
    output logic               push,
    output bbe_pkg::job_t      push_job
);
    import bbe_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1) > 0 ? $clog2(MAX_WIDTH + 1) : 1;

    front_state_t state_reg, state_next;
    logic [10:0]  width_reg, width_next;
    logic [12:0]  height_reg, height_next;
    logic [AW-1:0] col_reg, col_next;
    logic [12:0]  row_reg, row_next;
    logic [AW-1:0] drain_reg, drain_next;
    pixel_t       win_reg [6];
    pixel_t       win_next [6];
    pixel_t       pix_reg, pix_next;
    pixel_t       dr_old_reg [2];
    pixel_t       dr_old_next [2];
    pixel_t       dr_new_reg [2];
    pixel_t       dr_new_next [2];

    logic [WW-1:0] w_eff, w_m1_full;
    logic [AW-1:0] w_m1, lo, raddr, waddr;
    logic [12:0]  h_eff;
    logic         last_col, r1, r2, c1, c2, wide2, in_drain, tall;
    logic         dcol1, dcol2, d_last, ram_we;
    pixel_t       older_rdata, newer_rdata, older_wdata;
    pixel_t       col [3];

    always_comb begin
        if (width_reg == 11'd0) begin
            w_eff = WW'(1);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
    end

    assign w_m1_full = w_eff - WW'(1);
    assign w_m1      = w_m1_full[AW-1:0];
    assign h_eff     = (height_reg == 13'd0) ? 13'd1 : height_reg;
    assign last_col  = (col_reg == w_m1);
    assign r1        = (row_reg != 13'd0);
    assign r2        = (row_reg > 13'd1);
    assign c1        = (col_reg != '0);
    assign c2        = (col_reg > AW'(1));
    assign wide2     = (w_eff > WW'(1));
    assign tall      = (h_eff > 13'd1);
    assign in_drain  = (row_reg >= h_eff);

    // drain window columns lo..hi around drain_reg
    assign d_last = (drain_reg == w_m1);
    assign lo     = (drain_reg != '0) ? drain_reg - AW'(1) : '0;
    assign dcol1  = (drain_reg != '0) || !d_last;
    assign dcol2  = (drain_reg != '0) && !d_last;

    assign col[0] = older_rdata;
    assign col[1] = newer_rdata;
    assign col[2] = pix_reg;

    always_comb begin
        case (state_reg)
            ST_IDLE: raddr = in_drain ? lo : col_reg;
            ST_DR1:  raddr = lo + AW'(1);
            ST_DR2:  raddr = lo + AW'(2);
            default: raddr = col_reg;
        endcase
    end

    assign waddr       = col_reg;
    assign older_wdata = newer_rdata;
    assign ram_we      = (state_reg == ST_PIX);

    bbe_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH), .AW(AW)) u_older (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (older_wdata),
        .raddr (raddr),
        .rdata (older_rdata)
    );

    bbe_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH), .AW(AW)) u_newer (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (pix_reg),
        .raddr (raddr),
        .rdata (newer_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && q_empty;

    always_comb begin
        state_next  = state_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        drain_next  = drain_reg;
        pix_next    = pix_reg;
        for (int i = 0; i < 6; i++) begin
            win_next[i] = win_reg[i];
        end
        for (int i = 0; i < 2; i++) begin
            dr_old_next[i] = dr_old_reg[i];
            dr_new_next[i] = dr_new_reg[i];
        end
        push     = 1'b0;
        push_job = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (in_drain) begin
                        if (s_tuser) begin
                            state_next = ST_DR1;
                        end
                    end else if (!s_tuser) begin
                        pix_next   = s_tdata;
                        state_next = ST_PIX;
                    end
                end
            end
            ST_PIX: begin
                for (int k = 0; k < 3; k++) begin
                    for (int i = 0; i < 3; i++) begin
                        push_job.vld[k*3+i] = (k != 0 || c2) && (i != 0 || r2);
                    end
                end
                for (int i = 0; i < 3; i++) begin
                    push_job.pix[i]   = win_reg[i];
                    push_job.pix[3+i] = win_reg[3+i];
                    push_job.pix[6+i] = col[i];
                    win_next[i]       = win_reg[3+i];
                    win_next[3+i]     = col[i];
                end
                push_job.eor = !(last_col && r1);
                push         = r1 && c1;
                if (last_col && r1) begin
                    state_next = ST_PIX2;
                end else begin
                    state_next = ST_IDLE;
                    if (last_col) begin
                        col_next = '0;
                        row_next = row_reg + 13'd1;
                    end else begin
                        col_next = col_reg + AW'(1);
                    end
                end
            end
            ST_PIX2: begin
                // right edge window, using the just-shifted columns
                for (int k = 0; k < 2; k++) begin
                    for (int i = 0; i < 3; i++) begin
                        push_job.pix[k*3+i] = win_reg[k*3+i];
                        push_job.vld[k*3+i] = (k != 0 || wide2) && (i != 0 || r2);
                    end
                end
                push_job.eor = 1'b1;
                push         = 1'b1;
                col_next     = '0;
                row_next     = row_reg + 13'd1;
                state_next   = ST_IDLE;
            end
            ST_DR1: begin
                dr_old_next[0] = older_rdata;
                dr_new_next[0] = newer_rdata;
                state_next     = ST_DR2;
            end
            ST_DR2: begin
                dr_old_next[1] = older_rdata;
                dr_new_next[1] = newer_rdata;
                state_next     = ST_DR3;
            end
            ST_DR3: begin
                push_job.pix[0] = dr_old_reg[0];
                push_job.pix[1] = dr_new_reg[0];
                push_job.pix[3] = dr_old_reg[1];
                push_job.pix[4] = dr_new_reg[1];
                push_job.pix[6] = older_rdata;
                push_job.pix[7] = newer_rdata;
                push_job.vld[0] = tall;
                push_job.vld[1] = 1'b1;
                push_job.vld[3] = tall && dcol1;
                push_job.vld[4] = dcol1;
                push_job.vld[6] = tall && dcol2;
                push_job.vld[7] = dcol2;
                push_job.eor    = 1'b1;
                push_job.eof    = d_last;
                push            = 1'b1;
                state_next      = ST_IDLE;
                if (d_last) begin
                    row_next   = '0;
                    col_next   = '0;
                    drain_next = '0;
                end else begin
                    drain_next = drain_reg + AW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a write to the width or height register restarts the frame
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT) begin
                if (cfg_index == CFG_IMAGE_WIDTH) begin
                    width_next = cfg_data[10:0];
                end else begin
                    height_next = cfg_data;
                end
                col_next   = '0;
                row_next   = '0;
                drain_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= '0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            drain_reg  <= drain_next;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
        for (int i = 0; i < 2; i++) begin
            dr_old_reg[i] <= dr_old_next[i];
            dr_new_reg[i] <= dr_new_next[i];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bbe_queue.sv
// bbe_queue: short job queue between front and back
// depends on bbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbe_queue (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  bbe_pkg::job_t push_job,
    input  wire logic     pop,
    output bbe_pkg::job_t pop_job,
    output logic          empty,
    output logic          full
);
    import bbe_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bbe_back.sv
// bbe_back: sums a window job per channel, divides with rounding and
// holds the result in the output register. depends on bbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbe_back (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     job_valid,
    input  bbe_pkg::job_t job,
    output logic          pop,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output logic [23:0]   m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);
    import bbe_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [11:0] sum_reg [3];
    logic [11:0] sum_next [3];
    logic [3:0]  cnt_reg, cnt_next;
    logic        eor_reg, eof_reg;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] data_reg;
    logic        last_reg, user_reg;
    logic        adv_out, load_s1;
    logic [12:0] num [3];
    logic [32:0] prod [3];
    logic [23:0] quot;

    assign adv_out = !out_valid_reg || m_tready;
    assign pop     = job_valid && (!s1_valid_reg || adv_out);
    assign load_s1 = pop;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_next[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                if (job.vld[k]) begin
                    sum_next[ch] = sum_next[ch] + 12'(job.pix[k][ch*8 +: 8]);
                end
            end
        end
        cnt_next = 4'($countones(job.vld));
    end

    // (2*sum + count) / (2*count) by reciprocal multiply
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            num[ch]  = {sum_reg[ch], 1'b0} + 13'(cnt_reg);
            prod[ch] = 33'(num[ch]) * 33'(recip(cnt_reg));
            quot[ch*8 +: 8] = prod[ch][RECIP_SHIFT +: 8];
        end
    end

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (adv_out) begin
            out_valid_next = s1_valid_reg;
        end
        if (load_s1) begin
            s1_valid_next = 1'b1;
        end else if (adv_out) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_s1) begin
            for (int ch = 0; ch < 3; ch++) begin
                sum_reg[ch] <= sum_next[ch];
            end
            cnt_reg <= cnt_next;
            eor_reg <= job.eor;
            eof_reg <= job.eof;
        end
        if (adv_out && s1_valid_reg) begin
            data_reg <= quot;
            last_reg <= eor_reg;
            user_reg <= eof_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench: self-checking bench for box_blur_3x3_edge_aware_unit, a streaming 3x3 rgb blur
// drives pixel frames and drain ticks, predicts every blurred pixel and checks it
// depends on bbe_pkg and the unit's rtl
`timescale 1ns / 1ps

import bbe_pkg::*;

typedef struct {
    logic [23:0] rgb;
    logic        last;
    logic        eof;
} blur_px_t;

class blur_scoreboard;
    localparam int MAXW = 1024;

    logic [23:0] older_row[MAXW];
    logic [23:0] newer_row[MAXW];
    logic [23:0] win[6];        // 0..2 two columns back, 3..5 one back; top, mid, bottom
    int unsigned col_cnt, row_cnt, drain_cnt;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    int sum_r, sum_g, sum_b;
    blur_px_t fresh[$];
    blur_px_t expected_px[$];
    int errors;

    function new();
        foreach (win[i]) win[i] = '0;
        foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        col_cnt = 0;
        row_cnt = 0;
        drain_cnt = 0;
        width_reg = 11'd640;
        height_reg = 13'd480;
        errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [12:0] val);
        if (idx == CFG_IMAGE_WIDTH) width_reg = val[10:0];
        else if (idx == CFG_IMAGE_HEIGHT) height_reg = val;
        else return;
        col_cnt = 0;
        row_cnt = 0;
        drain_cnt = 0;
    endfunction

    function void add(logic [23:0] p);
        sum_r += p[7:0];
        sum_g += p[15:8];
        sum_b += p[23:16];
    endfunction

    function logic [7:0] mean8(int s, int cnt);
        return 8'((2 * s + cnt) / (2 * cnt));
    endfunction

    function void emit(int cnt, logic eof);
        blur_px_t e;
        e.rgb = {mean8(sum_b, cnt), mean8(sum_g, cnt), mean8(sum_r, cnt)};
        e.last = 1'b0;
        e.eof = eof;
        fresh.push_back(e);
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
    endfunction

    // accepted input transfer: work out the blurred pixels it releases
    function void note_input(logic drain, logic [23:0] px);
        int unsigned w, h, d, lo, hi, c, r, rows, cols;
        logic [23:0] cl[3];
        w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        fresh.delete();
        if (row_cnt >= h) begin
            if (!drain) return;
            d = (drain_cnt >= w) ? w - 1 : drain_cnt;
            lo = (d >= 1) ? d - 1 : 0;
            hi = (d + 1 < w) ? d + 1 : d;
            for (int unsigned j = lo; j <= hi; j++) begin
                add(newer_row[j]);
                if (h >= 2) add(older_row[j]);
            end
            emit((hi - lo + 1) * ((h >= 2) ? 2 : 1), d == w - 1);
            if (d == w - 1) begin
                row_cnt = 0;
                col_cnt = 0;
                drain_cnt = 0;
            end else begin
                drain_cnt = d + 1;
            end
        end else begin
            if (drain) return;
            c = (col_cnt >= w) ? 0 : col_cnt;
            r = row_cnt;
            cl[0] = older_row[c];
            cl[1] = newer_row[c];
            cl[2] = px;
            if (r >= 1 && c >= 1) begin
                rows = (r >= 2) ? 3 : 2;
                cols = (c >= 2) ? 3 : 2;
                for (int i = 0; i < 3; i++) begin
                    if (i == 0 && r < 2) continue;
                    add(cl[i]);
                    add(win[3 + i]);
                    if (c >= 2) add(win[i]);
                end
                emit(rows * cols, 1'b0);
            end
            for (int i = 0; i < 3; i++) begin
                win[i] = win[3 + i];
                win[3 + i] = cl[i];
            end
            older_row[c] = cl[1];
            newer_row[c] = px;
            if (c == w - 1) begin
                // row end also closes the rightmost window of the row above
                if (r >= 1) begin
                    rows = (r >= 2) ? 3 : 2;
                    cols = (w >= 2) ? 2 : 1;
                    for (int i = 0; i < 3; i++) begin
                        if (i == 0 && r < 2) continue;
                        add(win[3 + i]);
                        if (w >= 2) add(win[i]);
                    end
                    emit(rows * cols, 1'b0);
                end
                col_cnt = 0;
                row_cnt = r + 1;
            end else begin
                col_cnt = c + 1;
            end
        end
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i]) expected_px.push_back(fresh[i]);
    endfunction

    function void check(logic [23:0] rgb, logic last, logic eof);
        blur_px_t e;
        if (expected_px.size() == 0) begin
            $display("%0t: unexpected result rgb=%h last=%b eof=%b", $time, rgb, last, eof);
            errors++;
            return;
        end
        e = expected_px.pop_front();
        if (rgb !== e.rgb) begin
            $display("%0t: rgb expected %h actual %h", $time, e.rgb, rgb);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: tlast expected %b actual %b", $time, e.last, last);
            errors++;
        end
        if (eof !== e.eof) begin
            $display("%0t: tuser expected %b actual %b", $time, e.eof, eof);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // red_in, green_in, blue_in
    logic        s_tuser = 1'b0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // red_out, green_out, blue_out
    logic        m_tlast;          // end_of_run
    logic        m_tuser;          // end_of_frame

    blur_scoreboard sb = new();
    bit quiet = 0;
    bit pressure_req = 0;
    bit pressure_done = 0;
    int counted = 0;
    int unsigned cycles = 0;

    box_blur_3x3_edge_aware_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int gap;
        int hold;
        gap = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check(m_tdata, m_tlast, m_tuser);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (pressure_req) begin
                pressure_req = 0;
                hold = 400;
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else if (!quiet && aresetn && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(logic drain, logic [23:0] px);
        s_tvalid <= 1'b1;
        s_tuser <= drain;
        s_tdata <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(drain, px);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_px.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_px();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // one frame at the given register values; npix below a full frame stops early
    task automatic run_frame(int w_val, int h_val, int npix, bit noisy);
        int w, h;
        w = (w_val == 0) ? 1 : ((w_val > 1024) ? 1024 : w_val);
        h = (h_val == 0) ? 1 : h_val;
        write_reg(CFG_IMAGE_WIDTH, 13'(w_val));
        write_reg(CFG_IMAGE_HEIGHT, 13'(h_val));
        for (int i = 0; i < npix; i++) begin
            if (noisy && $urandom_range(0, 15) == 0) send(1'b1, rand_px());
            send(1'b0, rand_px());
            counted++;
        end
        if (npix >= w * h) begin
            for (int i = 0; i < w; i++) begin
                if (noisy && $urandom_range(0, 15) == 0) send(1'b0, rand_px());
                send(1'b1, rand_px());
                counted++;
            end
        end
        wait_idle();
    endtask

    initial begin
        int w, h;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: part of the first row, nothing comes out yet
        for (int i = 0; i < 20; i++) send(1'b0, rand_px());
        wait_idle();

        // small frame with a stray drain tick and a pixel during draining
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        write_reg(CFG_IMAGE_HEIGHT, 13'd3);
        send(1'b1, 24'hffffff);
        for (int i = 0; i < 9; i++) send(1'b0, (i % 2) ? 24'hffffff : 24'h000000);
        send(1'b0, 24'h123456);
        for (int i = 0; i < 3; i++) send(1'b1, 24'h000000);
        wait_idle();

        // register extremes and out-of-range values
        run_frame(0, 3, 3, 1);
        run_frame(1, 40, 40, 0);
        run_frame(5, 0, 5, 1);
        run_frame(2, 1, 2, 1);

        counted = 0;
        while (counted < 500) begin
            if (counted > 380) quiet = 1;
            if (counted > 150 && !pressure_done) begin
                pressure_req = 1;
                pressure_done = 1;
            end
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) run_frame(w, h, $urandom_range(0, w * h - 1), 1);
            else run_frame(w, h, w * h, 1);
        end
        wait_idle();

        if (sb.errors == 0 && sb.expected_px.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
